[rtl/rhsl_pkg.sv]
// Package for the RGB to HSL converter.
// Holds the division lane and cell payload types and the conversion constants; no dependencies.

package rhsl_pkg;

  localparam int unsigned CELL_COUNT = 9;

  localparam logic [8:0]  HUE_OFF_RED_LOW = 9'd0;
  localparam logic [8:0]  HUE_OFF_RED_WRAP = 9'd360;
  localparam logic [8:0]  HUE_OFF_GREEN = 9'd120;
  localparam logic [8:0]  HUE_OFF_BLUE = 9'd240;
  localparam logic [8:0]  HUE_MAX = 9'd360;
  localparam logic [8:0]  PCT_MAX = 9'd100;
  localparam logic [8:0]  SUM_FULL = 9'd510;
  localparam logic [8:0]  SUM_HALF = 9'd255;
  localparam logic [14:0] LIT_RECIP = 15'd20561;

  // one division lane: partial remainder, numerator bits still to enter,
  // quotient so far and divisor
  typedef struct packed {
    logic [7:0] rem;
    logic [8:0] num;
    logic [8:0] quo;
    logic [7:0] den;
  } div_lane_t;

  typedef struct packed {
    div_lane_t  hue;
    div_lane_t  sat;
    logic       grey;
    logic [6:0] lit;
  } cell_t;

endpackage

[rtl/rhsl_front.sv]
// Input stage of the RGB to HSL converter: max, min, sector, numerators and lightness.
// Depends on rhsl_pkg.

module rhsl_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output rhsl_pkg::cell_t      dn_data
);

  logic               valid_r;
  rhsl_pkg::cell_t    data_r;
  rhsl_pkg::cell_t    data_nxt;

  logic [7:0]         mx;
  logic [7:0]         mn;
  logic [7:0]         rng;
  logic [8:0]         sum;
  logic signed [8:0]  diff;
  logic [8:0]         off;
  logic [16:0]        prod_off;
  logic signed [16:0] prod_dif;
  logic [16:0]        hnum;
  logic [14:0]        snum;
  logic [7:0]         sden;
  logic [12:0]        lx;
  logic [27:0]        lprod;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    rng = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};

    if (mx == red) begin
      diff = $signed({1'b0, green}) - $signed({1'b0, blue});
      off  = (green >= blue) ? rhsl_pkg::HUE_OFF_RED_LOW : rhsl_pkg::HUE_OFF_RED_WRAP;
    end else if (mx == green) begin
      diff = $signed({1'b0, blue}) - $signed({1'b0, red});
      off  = rhsl_pkg::HUE_OFF_GREEN;
    end else begin
      diff = $signed({1'b0, red}) - $signed({1'b0, green});
      off  = rhsl_pkg::HUE_OFF_BLUE;
    end

    prod_off = {8'd0, off} * {9'd0, rng};
    prod_dif = 17'sd60 * {{8{diff[8]}}, diff};
    hnum     = prod_off + unsigned'(prod_dif);

    snum = {7'd0, rng} * 15'd100;
    sden = (sum <= rhsl_pkg::SUM_HALF) ? sum[7:0] : 8'(rhsl_pkg::SUM_FULL - sum);

    lx    = {1'b0, sum, 3'b000} + {3'b000, sum, 1'b0};
    lprod = {15'd0, lx} * {13'd0, rhsl_pkg::LIT_RECIP};

    data_nxt.hue.rem = hnum[16:9];
    data_nxt.hue.num = hnum[8:0];
    data_nxt.hue.quo = '0;
    data_nxt.hue.den = rng;
    data_nxt.sat.rem = {2'b00, snum[14:9]};
    data_nxt.sat.num = snum[8:0];
    data_nxt.sat.quo = '0;
    data_nxt.sat.den = sden;
    data_nxt.grey    = (rng == 8'd0);
    data_nxt.lit     = lprod[26:20];
  end

  assign in_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[rtl/rhsl_cell.sv]
// Division cell of the RGB to HSL converter: one quotient bit for hue and for saturation.
// Depends on rhsl_pkg.

module rhsl_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  rhsl_pkg::cell_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output rhsl_pkg::cell_t dn_data
);

  logic            valid_r;
  rhsl_pkg::cell_t data_r;
  rhsl_pkg::cell_t data_nxt;

  function automatic rhsl_pkg::div_lane_t step(input rhsl_pkg::div_lane_t l);
    rhsl_pkg::div_lane_t o;
    logic [8:0]          rs;
    logic                ge;
    rs     = {l.rem, l.num[8]};
    ge     = (rs >= {1'b0, l.den});
    o.rem  = ge ? 8'(rs - {1'b0, l.den}) : rs[7:0];
    o.num  = {l.num[7:0], 1'b0};
    o.quo  = {l.quo[7:0], ge};
    o.den  = l.den;
    return o;
  endfunction

  always_comb begin
    data_nxt      = up_data;
    data_nxt.hue  = step(up_data.hue);
    data_nxt.sat  = step(up_data.sat);
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[rtl/rhsl_back.sv]
// Output stage of the RGB to HSL converter: grey handling, clamping, result register.
// Depends on rhsl_pkg.

module rhsl_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  rhsl_pkg::cell_t up_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [8:0]      hue,
  output logic [6:0]      saturation,
  output logic [6:0]      lightness
);

  logic       valid_r;
  logic [8:0] hue_r;
  logic [6:0] sat_r;
  logic [6:0] lit_r;
  logic [8:0] hue_nxt;
  logic [6:0] sat_nxt;

  always_comb begin
    if (up_data.grey) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end else begin
      hue_nxt = (up_data.hue.quo > rhsl_pkg::HUE_MAX) ? rhsl_pkg::HUE_MAX : up_data.hue.quo;
      sat_nxt = (up_data.sat.quo > rhsl_pkg::PCT_MAX) ? rhsl_pkg::PCT_MAX[6:0]
                                                       : up_data.sat.quo[6:0];
    end
  end

  assign up_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      lit_r <= up_data.lit;
    end
  end

  assign out_valid  = valid_r;
  assign hue        = hue_r;
  assign saturation = sat_r;
  assign lightness  = lit_r;

endmodule

[rtl/rgb_to_hsl_converter_core.sv]
// Top level of the RGB to HSL converter.
// Depends on rhsl_pkg, rhsl_front, rhsl_cell and rhsl_back.
//
// Usage:
//   Input stream: one pixel per transfer, in_tdata = {blue, green, red}.
//   Output stream: one result per pixel, in the same order,
//   out_tdata = {pad, lightness, saturation, hue}.
//   Hue is in whole degrees 0..359, saturation and lightness in whole
//   percent 0..100, all truncated; a grey pixel gives hue 0 and saturation 0.
//   Pipeline: eleven register stages (one front stage, nine division cells,
//   one output register), which a pixel passes in that order from the
//   input transfer to out_tvalid.
//   Throughput: one pixel per cycle unless stalled; each of the nine
//   restoring-division cells gives a quotient bit of hue and of saturation.
//   Every stage holds its own valid flag, so bubbles close up and the
//   input keeps accepting until all eleven stages are full.
//   Receiver stall: the output holds its result and the stages behind it
//   fill up; in_tready falls only when every stage is occupied.
//   Reset clears every stage's valid flag; no pixel is in flight afterwards.

module rgb_to_hsl_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // hue [8:0], saturation [15:9], lightness [22:16], zero [23]
);

  localparam int unsigned N = rhsl_pkg::CELL_COUNT;

  logic            ch_valid [N+1];
  logic            ch_ready [N+1];
  rhsl_pkg::cell_t ch_data  [N+1];

  logic [8:0] hue;
  logic [6:0] saturation;
  logic [6:0] lightness;

  rhsl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .red      (in_tdata[7:0]),
    .green    (in_tdata[15:8]),
    .blue     (in_tdata[23:16]),
    .dn_valid (ch_valid[0]),
    .dn_ready (ch_ready[0]),
    .dn_data  (ch_data[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    rhsl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (ch_valid[i]),
      .up_ready (ch_ready[i]),
      .up_data  (ch_data[i]),
      .dn_valid (ch_valid[i+1]),
      .dn_ready (ch_ready[i+1]),
      .dn_data  (ch_data[i+1])
    );
  end

  rhsl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (ch_valid[N]),
    .up_ready   (ch_ready[N]),
    .up_data    (ch_data[N]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness)
  );

  assign out_tdata = {1'b0, lightness, saturation, hue};

endmodule

[rtl/rhsl_checker.sv]
// Port-level checker for the RGB to HSL converter, bound to the top level.
// Depends on rgb_to_hsl_converter_core.

module rhsl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[8:0] <= 9'd360 && out_tdata[15:9] <= 7'd100
                   && out_tdata[22:16] <= 7'd100 && !out_tdata[23])
    else $error("result out of range");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind rgb_to_hsl_converter_core rhsl_checker u_rhsl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
